@@ rtl/core/cpr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants and types of the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

  // default sizing of the frame table
  localparam int FRAME_COUNT_DEF  = 16;
  localparam int ADDRESS_BITS_DEF = 48;

  // fixed widths of the stream fields
  localparam int PAGE_W      = 48;
  localparam int INDEX_W     = 4;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // one result word, first field in the highest bits when packed
  typedef struct packed {
    logic [PAGE_W-1:0]  evicted_address;
    logic               evicted_valid;
    logic [INDEX_W-1:0] frame_index;
    logic               hit;
    logic               ignored;
  } result_t;

endpackage : cpr_pkg
`default_nettype wire

@@ rtl/core/clock_page_replacement.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clock_page_replacement
// Second-chance page replacement over a table of frames held in a memory.
// ----------------------------------------------------------------------------
// One page address goes in per word and one result word comes out. The frame
// addresses sit in a synchronous memory, read one entry per cycle, so the
// block handles one word at a time. A zero address skips the lookup. A lookup
// walks the table through the memory read port, one frame per cycle. A hit
// stops the walk early. A miss with a free frame left loads it after the full
// walk. A miss on a full table adds the clock sweep, one frame per cycle, then
// reads and replaces the victim. A new address is taken while the previous
// result still waits on the output register. There is no clearing pass: the
// referenced and occupied bits are flip-flops that reset clears at once.
module clock_page_replacement #(
  parameter int FRAME_COUNT  = cpr_pkg::FRAME_COUNT_DEF,
  parameter int ADDRESS_BITS = cpr_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // page_address[47:0]
  input  wire logic [cpr_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // ignored[0], hit[1], frame_index[5:2], evicted_valid[6],
  // evicted_address[54:7], zero[55]
  output logic [cpr_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready
);
  import cpr_pkg::*;

  localparam int IDX_W = $clog2(FRAME_COUNT);
  localparam logic [IDX_W-1:0] LAST_FRAME = IDX_W'(FRAME_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SWEEP,
    S_EVICT,
    S_DONE
  } state_t;

  state_t                  state;
  logic [ADDRESS_BITS-1:0] addr;
  logic [IDX_W-1:0]        scan_idx;
  logic                    cmp_valid;
  logic [IDX_W-1:0]        cmp_idx;
  logic [IDX_W-1:0]        slot;
  logic [IDX_W-1:0]        clock_hand;
  logic [IDX_W-1:0]        fill_pointer;
  logic                    table_full;
  logic [FRAME_COUNT-1:0]  ref_bits;
  logic [FRAME_COUNT-1:0]  occupied;
  result_t                 res;

  // frame address memory
  logic [ADDRESS_BITS-1:0] frame_mem [FRAME_COUNT];
  logic [ADDRESS_BITS-1:0] rd_data;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;

  logic [ADDRESS_BITS-1:0] in_addr;
  logic                    s_accept;
  logic                    m_free;
  logic                    cmp_hit;
  logic                    cmp_last;
  logic [IDX_W-1:0]        fill_next;

  function automatic logic [IDX_W-1:0] next_frame(input logic [IDX_W-1:0] f);
    next_frame = (f == LAST_FRAME) ? '0 : f + IDX_W'(1);
  endfunction

  // input narrowing and handshake
  assign in_addr  = ADDRESS_BITS'(s_tdata[PAGE_W-1:0]);
  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign m_free   = !m_tvalid || m_tready;

  // lookup compare on the word read last cycle
  assign cmp_hit   = cmp_valid && occupied[cmp_idx] && (rd_data == addr);
  assign cmp_last  = cmp_valid && (cmp_idx == LAST_FRAME);
  assign fill_next = next_frame(fill_pointer);

  // memory port control
  always_comb begin
    rd_addr = (state == S_SCAN) ? scan_idx : slot;
    wr_en   = 1'b0;
    wr_addr = slot;
    if (state == S_SCAN && !cmp_hit && cmp_last && !table_full) begin
      wr_en   = 1'b1;
      wr_addr = fill_pointer;
    end else if (state == S_EVICT) begin
      wr_en   = 1'b1;
      wr_addr = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= addr;
    end
    rd_data <= frame_mem[rd_addr];
  end

  // control sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cmp_valid    <= 1'b0;
      clock_hand   <= '0;
      fill_pointer <= '0;
      table_full   <= 1'b0;
      ref_bits     <= '0;
      occupied     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // drop valid once taken, unless a new word replaces it
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            addr      <= in_addr;
            // ignored sits in the lowest bit of the result
            res       <= {{($bits(result_t)-1){1'b0}}, in_addr == '0};
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            if (in_addr == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          priority if (cmp_hit) begin
            ref_bits[cmp_idx] <= 1'b1;
            res.hit           <= 1'b1;
            res.frame_index   <= INDEX_W'(cmp_idx);
            state             <= S_DONE;
          end else if (cmp_last && !table_full) begin
            // load into the next free frame
            ref_bits[fill_pointer] <= 1'b1;
            occupied[fill_pointer] <= 1'b1;
            fill_pointer           <= fill_next;
            table_full             <= (fill_next == clock_hand);
            res.frame_index        <= INDEX_W'(fill_pointer);
            state                  <= S_DONE;
          end else if (cmp_last) begin
            slot  <= clock_hand;
            state <= S_SWEEP;
          end else begin
            cmp_valid <= 1'b1;
            cmp_idx   <= scan_idx;
            scan_idx  <= scan_idx + IDX_W'(1);
          end
        end
        S_SWEEP: begin
          // second chance: clear and pass, or stop with the read issued
          if (ref_bits[slot]) begin
            ref_bits[slot] <= 1'b0;
            slot           <= next_frame(slot);
          end else begin
            state <= S_EVICT;
          end
        end
        S_EVICT: begin
          ref_bits[slot]      <= 1'b1;
          occupied[slot]      <= 1'b1;
          clock_hand          <= next_frame(slot);
          fill_pointer        <= next_frame(slot);
          res.evicted_valid   <= 1'b1;
          res.evicted_address <= PAGE_W'(rd_data);
          res.frame_index     <= INDEX_W'(slot);
          state               <= S_DONE;
        end
        S_DONE: begin
          if (m_free) begin
            m_tdata  <= OUT_TDATA_W'(res);
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a full table always has the fill pointer parked on the hand
  a_full_hand: assert property (@(posedge clk) disable iff (rst)
    table_full |-> (fill_pointer == clock_hand))
    else $error("table full with fill pointer off the clock hand");

  // the victim frame has its referenced bit clear
  a_victim_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVICT) |-> !ref_bits[slot])
    else $error("evicting a referenced frame");

  // a sweep only starts on a full table
  a_sweep_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> table_full)
    else $error("clock sweep on a table with free frames");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[1] && m_tdata[6]))
    else $error("result with both hit and eviction");

endmodule : clock_page_replacement
`default_nettype wire

@@ test/clock_page_replacement_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clock_page_replacement_test
// Self-checking bench for the second-chance page replacement block.
// ----------------------------------------------------------------------------
// A short directed table fills the frame table, forces a full sweep that
// clears every referenced bit, and covers the zero address, hits and misses.
// Random phases follow. Each phase draws its pages from a pool of a random
// size, so the mix of hits, loads and evictions changes from phase to phase.
// A clock-replacement predictor in the bench gives the expected result word
// for each accepted page not typed in the directed table. Each result word
// is checked field by field. The sender bursts with gaps, the receiver stalls in modes.
// ----------------------------------------------------------------------------
module clock_page_replacement_test;
  import cpr_pkg::*;

  localparam int FRAMES      = FRAME_COUNT_DEF;
  localparam int RANDOM_PAGES = 950;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_TAIL  = 2 * FRAMES + 8;

  // one row of the directed table
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              typed;
    result_t           want;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready;

  // predictor state of the frame table
  logic [PAGE_W-1:0]  frame_page [FRAMES];
  logic               ref_bit [FRAMES];
  logic [INDEX_W-1:0] hand;
  logic [INDEX_W-1:0] fill;
  logic               table_full;

  result_t     expected_words[$];
  stim_row_t   directed_rows[$];
  logic [PAGE_W-1:0] page_pool[$];
  int          error_count;
  int          burst_left;
  result_t     got_word;
  result_t     want_word;

  clock_page_replacement u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected result of one page reference, updates the predicted table
  function automatic result_t clock_replace(input logic [PAGE_W-1:0] page);
    result_t            r;
    logic [INDEX_W-1:0] slot;
    int                 i;
    int                 sweep;
    bit                 found;
    r = '0;
    found = 1'b0;
    if (page == '0) begin
      r.ignored = 1'b1;
      return r;
    end
    // lookup, lowest matching frame wins
    for (i = 0; i < FRAMES; i++) begin
      if (!found && frame_page[i] == page) begin
        found = 1'b1;
        ref_bit[i] = 1'b1;
        r.hit = 1'b1;
        r.frame_index = INDEX_W'(i);
      end
    end
    if (found) return r;
    // free frame left: load at the fill pointer
    if (!table_full) begin
      slot = fill;
      frame_page[slot] = page;
      ref_bit[slot] = 1'b1;
      fill = slot + 1'b1;
      if (fill == hand) table_full = 1'b1;
      r.frame_index = slot;
      return r;
    end
    // sweep the hand, giving each referenced frame its second chance
    slot = hand;
    for (sweep = 0; sweep <= FRAMES && ref_bit[slot]; sweep++) begin
      ref_bit[slot] = 1'b0;
      slot = slot + 1'b1;
    end
    r.evicted_valid = 1'b1;
    r.evicted_address = frame_page[slot];
    r.frame_index = slot;
    frame_page[slot] = page;
    ref_bit[slot] = 1'b1;
    hand = slot + 1'b1;
    fill = hand;
    return r;
  endfunction

  function automatic result_t make_word(input logic ign, input logic hit,
                                        input logic [INDEX_W-1:0] idx,
                                        input logic ev, input logic [PAGE_W-1:0] ev_page);
    result_t r;
    r.ignored = ign;
    r.hit = hit;
    r.frame_index = idx;
    r.evicted_valid = ev;
    r.evicted_address = ev_page;
    return r;
  endfunction

  task automatic add_row(input logic [PAGE_W-1:0] page, input logic typed, input result_t want);
    directed_rows.push_back('{page: page, typed: typed, want: want});
  endtask

  function automatic logic [PAGE_W-1:0] random_page();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // drive one page word in a burst, predict it once it is taken
  task automatic send_page(input logic [PAGE_W-1:0] page, input logic typed,
                           input result_t want);
    result_t predicted;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    s_tdata  <= page;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predicted = clock_replace(page);
    expected_words.push_back(typed ? want : predicted);
    burst_left--;
    @(negedge clk);
  endtask

  // hold the sender off until every pending result word has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // receiver stall pattern: always ready, random, or mostly stalled
  initial begin : receiver
    int mode;
    int mode_left;
    int phase;
    mode = 0;
    mode_left = 0;
    phase = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left <= 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(64, 200);
      end
      mode_left--;
      phase++;
      case (mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          m_tready <= (phase % 11 == 0);
        end
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_word = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        error_count++;
      end else begin
        want_word = expected_words.pop_front();
        if (got_word.ignored !== want_word.ignored) begin
          $error("ignored: expected %h, got %h", want_word.ignored, got_word.ignored);
          error_count++;
        end
        if (got_word.hit !== want_word.hit) begin
          $error("hit: expected %h, got %h", want_word.hit, got_word.hit);
          error_count++;
        end
        if (got_word.frame_index !== want_word.frame_index) begin
          $error("frame_index: expected %h, got %h",
                 want_word.frame_index, got_word.frame_index);
          error_count++;
        end
        if (got_word.evicted_valid !== want_word.evicted_valid) begin
          $error("evicted_valid: expected %h, got %h",
                 want_word.evicted_valid, got_word.evicted_valid);
          error_count++;
        end
        if (got_word.evicted_address !== want_word.evicted_address) begin
          $error("evicted_address: expected %h, got %h",
                 want_word.evicted_address, got_word.evicted_address);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles where neither side moves a word
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("[clock_page_replacement] ERROR");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int i;
    int sent;
    int phase_len;
    int pool_size;
    int pick;
    logic [PAGE_W-1:0] page;
    error_count = 0;
    burst_left  = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    for (i = 0; i < FRAMES; i++) begin
      frame_page[i] = '0;
      ref_bit[i] = 1'b0;
    end
    hand = '0;
    fill = '0;
    table_full = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: zero address, extremes, fill, full sweep, hits and misses
    add_row(48'h0, 1'b1, make_word(1'b1, 1'b0, 4'd0, 1'b0, 48'h0));
    add_row(48'hFFFF_FFFF_FFFF, 1'b1, make_word(1'b0, 1'b0, 4'd0, 1'b0, 48'h0));
    add_row(48'hFFFF_FFFF_FFFF, 1'b1, make_word(1'b0, 1'b1, 4'd0, 1'b0, 48'h0));
    add_row(48'h0000_0000_0001, 1'b1, make_word(1'b0, 1'b0, 4'd1, 1'b0, 48'h0));
    add_row(48'h8000_0000_0000, 1'b1, make_word(1'b0, 1'b0, 4'd2, 1'b0, 48'h0));
    add_row(48'h5555_5555_5555, 1'b1, make_word(1'b0, 1'b0, 4'd3, 1'b0, 48'h0));
    add_row(48'hAAAA_AAAA_AAAA, 1'b1, make_word(1'b0, 1'b0, 4'd4, 1'b0, 48'h0));
    for (i = 0; i < FRAMES - 5; i++) begin
      add_row(48'h3 << (4 * i + 2), 1'b1,
              make_word(1'b0, 1'b0, INDEX_W'(i + 5), 1'b0, 48'h0));
    end
    // table full with every bit set: the sweep clears all and wraps to frame 0
    add_row(48'h0123_4567_89AB, 1'b1,
            make_word(1'b0, 1'b0, 4'd0, 1'b1, 48'hFFFF_FFFF_FFFF));
    add_row(48'h0, 1'b1, make_word(1'b1, 1'b0, 4'd0, 1'b0, 48'h0));
    add_row(48'h0000_0000_0001, 1'b1, make_word(1'b0, 1'b1, 4'd1, 1'b0, 48'h0));
    add_row(48'hFEDC_BA98_7654, 1'b0, '0);
    add_row(48'hFFFF_FFFF_FFFF, 1'b0, '0);

    foreach (directed_rows[k]) begin
      send_page(directed_rows[k].page, directed_rows[k].typed, directed_rows[k].want);
    end
    wait_drained();

    // random phases, each with its own page pool
    sent = 0;
    while (sent < RANDOM_PAGES) begin
      pool_size = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40)
                                              : $urandom_range(3, 20);
      page_pool.delete();
      for (i = 0; i < pool_size; i++) page_pool.push_back(random_page());
      phase_len = $urandom_range(40, 120);
      for (i = 0; i < phase_len && sent < RANDOM_PAGES; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) page = '0;
        else if (pick < 15) page = random_page();
        else page = page_pool[$urandom_range(0, pool_size - 1)];
        send_page(page, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    // drain and let the block settle
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d result words never arrived", expected_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[clock_page_replacement] OK");
    end else begin
      $display("[clock_page_replacement] ERROR");
    end
    $finish;
  end

endmodule : clock_page_replacement_test
`default_nettype wire
